[design/bpdc_pkg.sv]
// Package for the button press duration classifier.
// Holds the press class type, lane status structs, register codes and the
// classify function. No dependencies.
package bpdc_pkg;

    localparam int MASK_WIDTH  = 8;
    localparam int ELAPSED_W   = 16;
    localparam int TICK_W      = 10;
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 16;

    localparam logic [ELAPSED_W-1:0] ELAPSED_MAX = {ELAPSED_W{1'b1}};

    // Register indexes of the configuration port
    localparam logic [CFG_INDEX_W-1:0] REG_MIN_PRESS  = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_LONG_PRESS = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_TICK       = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_DIMMING    = 3'd3;

    typedef enum logic [1:0] {
        CLS_NONE  = 2'd0,
        CLS_SHORT = 2'd1,
        CLS_LONG  = 2'd2
    } press_class_t;

    // Timing thresholds shared by all lanes
    typedef struct packed {
        logic [ELAPSED_W-1:0] min_press_ms;
        logic [ELAPSED_W-1:0] long_press_ms;
        logic [TICK_W-1:0]    tick_ms;
    } lane_cfg_t;

    // What one lane found for one scan
    typedef struct packed {
        logic         pressed;
        press_class_t cls;
    } lane_res_t;

    function automatic press_class_t classify(
        input logic [ELAPSED_W-1:0] t,
        input logic [ELAPSED_W-1:0] min_ms,
        input logic [ELAPSED_W-1:0] long_ms
    );
        press_class_t k;
        k = CLS_NONE;
        if (t > min_ms) begin
            if ((long_ms != '0) && (t > long_ms)) begin
                k = CLS_LONG;
            end
            else begin
                k = CLS_SHORT;
            end
        end
        return k;
    endfunction

endpackage

[design/bpdc_lane.sv]
// One button lane: started flag, elapsed counter and per-scan class.
// Depends on bpdc_pkg.
module bpdc_lane (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               load,
    input  logic               pressed,
    input  bpdc_pkg::lane_cfg_t cfg,
    output bpdc_pkg::lane_res_t res
);
    import bpdc_pkg::*;

    logic                 started_reg, started_next;
    logic [ELAPSED_W-1:0] elapsed_reg, elapsed_next;
    lane_res_t            res_reg, res_next;
    logic [ELAPSED_W:0]   sum;
    logic [ELAPSED_W-1:0] advanced;

    // Saturating advance of the elapsed count
    assign sum      = {1'b0, elapsed_reg} + {{(ELAPSED_W + 1 - TICK_W){1'b0}}, cfg.tick_ms};
    assign advanced = sum[ELAPSED_W] ? ELAPSED_MAX : sum[ELAPSED_W-1:0];

    always_comb
    begin
        started_next     = 1'b0;
        elapsed_next     = '0;
        res_next.pressed = pressed;
        res_next.cls     = CLS_NONE;
        if (pressed) begin
            started_next = 1'b1;
            if (started_reg) begin
                elapsed_next = advanced;
                res_next.cls = classify(advanced, cfg.min_press_ms, cfg.long_press_ms);
            end
        end
        else if (started_reg) begin
            // judge the release on the advanced count, then drop the press
            res_next.cls = classify(advanced, cfg.min_press_ms, cfg.long_press_ms);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            started_reg <= 1'b0;
            elapsed_reg <= '0;
            res_reg     <= '{pressed: 1'b0, cls: CLS_NONE};
        end
        else if (load) begin
            started_reg <= started_next;
            elapsed_reg <= elapsed_next;
            res_reg     <= res_next;
        end
    end

    assign res = res_reg;

endmodule

[design/bpdc_merge.sv]
// Merge stage: combines lane results into indicator, release masks and
// dimming request. Depends on bpdc_pkg.
module bpdc_merge #(
    parameter int NUM_BUTTONS = 8
) (
    input  bpdc_pkg::lane_res_t res [NUM_BUTTONS],
    input  logic [bpdc_pkg::MASK_WIDTH-1:0] dimming_mask,
    output logic [1:0]                      indicator,
    output logic [bpdc_pkg::MASK_WIDTH-1:0] released_mask,
    output logic [bpdc_pkg::MASK_WIDTH-1:0] long_mask,
    output logic                            dim_request
);
    import bpdc_pkg::*;

    localparam int NOUT = (NUM_BUTTONS < MASK_WIDTH) ? NUM_BUTTONS : MASK_WIDTH;

    always_comb
    begin
        indicator     = CLS_NONE;
        released_mask = '0;
        long_mask     = '0;
        // highest-numbered valid held button wins
        for (int b = 0; b < NUM_BUTTONS; b++) begin
            if (res[b].pressed && (res[b].cls != CLS_NONE)) begin
                indicator = res[b].cls;
            end
        end
        for (int b = 0; b < NOUT; b++) begin
            released_mask[b] = !res[b].pressed && (res[b].cls != CLS_NONE);
            long_mask[b]     = !res[b].pressed && (res[b].cls == CLS_LONG);
        end
        dim_request = |(released_mask & dimming_mask);
    end

endmodule

[design/button_press_duration_classifier.sv]
// Top level of the button press duration classifier.
// Instantiates one bpdc_lane per button and bpdc_merge; uses bpdc_pkg.
//
// Usage:
//   Input channel (in_valid / in_stall): one word per periodic scan, the
//   pressed_mask with one bit per button. A word is taken at a rising edge
//   with in_valid high and in_stall low.
//   Output channel (out_valid / out_stall): one result word per scan with
//   indicator, released_mask, long_mask and dim_request, taken at a rising
//   edge with out_valid high and out_stall low.
//   Configuration channel (cfg_valid / cfg_ready / cfg_index / cfg_data):
//   index 0 min_press_ms, 1 long_press_ms, 2 tick_ms, 3 dimming_mask;
//   other indexes are ignored. cfg_ready is always high. Write only while
//   the block is idle.
// Path: a taken scan is registered in the lane result stage, then in the output register.
// Throughput: one scan per cycle while in_stall is low; every button lane
//   updates its counter in parallel, and the lane result stage plus the
//   output register form a two-word pipeline.
// Reset: all buttons not started with zero elapsed time, registers back to
//   their defaults (100, 0, 100, 0), pipeline empty.
// Stall: while out_stall holds the output word, one more scan is taken into
//   the lane stage; after that in_stall rises until the output moves.
module button_press_duration_classifier #(
    parameter int NUM_BUTTONS = 8
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    output logic                                 in_stall,
    input  logic [bpdc_pkg::MASK_WIDTH-1:0]      pressed_mask,
    output logic                                 out_valid,
    input  logic                                 out_stall,
    output logic [1:0]                           indicator,
    output logic [bpdc_pkg::MASK_WIDTH-1:0]      released_mask,
    output logic [bpdc_pkg::MASK_WIDTH-1:0]      long_mask,
    output logic                                 dim_request,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [bpdc_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  logic [bpdc_pkg::CFG_DATA_W-1:0]      cfg_data
);
    import bpdc_pkg::*;

    // Configuration registers
    logic [ELAPSED_W-1:0]  min_press_reg;
    logic [ELAPSED_W-1:0]  long_press_reg;
    logic [TICK_W-1:0]     tick_reg;
    logic [MASK_WIDTH-1:0] dimming_reg;
    lane_cfg_t             lane_cfg;

    // Pipeline control
    logic in_accept;
    logic out_adv;
    logic s1_valid_reg, s1_valid_next;
    logic out_valid_reg, out_valid_next;

    // Lane results and merged word
    lane_res_t             lane_res [NUM_BUTTONS];
    logic [1:0]            ind_m;
    logic [MASK_WIDTH-1:0] rel_m;
    logic [MASK_WIDTH-1:0] lng_m;
    logic                  dim_m;

    logic [1:0]            indicator_reg;
    logic [MASK_WIDTH-1:0] released_reg;
    logic [MASK_WIDTH-1:0] long_reg;
    logic                  dim_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            min_press_reg  <= 16'd100;
            long_press_reg <= 16'd0;
            tick_reg       <= 10'd100;
            dimming_reg    <= 8'd0;
        end
        else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                REG_MIN_PRESS:  min_press_reg  <= cfg_data;
                REG_LONG_PRESS: long_press_reg <= cfg_data;
                REG_TICK:       tick_reg       <= cfg_data[TICK_W-1:0];
                REG_DIMMING:    dimming_reg    <= cfg_data[MASK_WIDTH-1:0];
                default:        ;
            endcase
        end
    end

    assign lane_cfg = '{min_press_ms: min_press_reg,
                        long_press_ms: long_press_reg,
                        tick_ms: tick_reg};

    // Output moves when empty or taken; lane stage refills when it moves on
    assign out_adv   = !out_valid_reg || !out_stall;
    assign in_stall  = s1_valid_reg && !out_adv;
    assign in_accept = in_valid && !in_stall;

    always_comb
    begin
        s1_valid_next  = s1_valid_reg;
        out_valid_next = out_valid_reg;
        if (out_adv) begin
            out_valid_next = s1_valid_reg;
            s1_valid_next  = in_accept;
        end
        else if (in_accept) begin
            // output held, lane stage was empty: keep the new scan there
            s1_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // One lane per button; buttons past the mask width never see a press
    for (genvar b = 0; b < NUM_BUTTONS; b++) begin : g_lane
        logic lane_pressed;
        if (b < MASK_WIDTH) begin : g_in
            assign lane_pressed = pressed_mask[b];
        end
        else begin : g_none
            assign lane_pressed = 1'b0;
        end
        bpdc_lane u_lane (
            .clk     (clk),
            .rst_n   (rst_n),
            .load    (in_accept),
            .pressed (lane_pressed),
            .cfg     (lane_cfg),
            .res     (lane_res[b])
        );
    end

    bpdc_merge #(
        .NUM_BUTTONS (NUM_BUTTONS)
    ) u_merge (
        .res           (lane_res),
        .dimming_mask  (dimming_reg),
        .indicator     (ind_m),
        .released_mask (rel_m),
        .long_mask     (lng_m),
        .dim_request   (dim_m)
    );

    // Output word register; hold while stalled
    always_ff @(posedge clk)
    begin
        if (out_adv && s1_valid_reg) begin
            indicator_reg <= ind_m;
            released_reg  <= rel_m;
            long_reg      <= lng_m;
            dim_reg       <= dim_m;
        end
    end

    assign out_valid     = out_valid_reg;
    assign indicator     = indicator_reg;
    assign released_mask = released_reg;
    assign long_mask     = long_reg;
    assign dim_request   = dim_reg;

    a_ind_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (indicator_reg != 2'd3))
        else $error("indicator code out of range");

    a_long_subset: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> ((long_reg & ~released_reg) == '0))
        else $error("long release without valid release");

    a_dim_match: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (dim_reg == |(released_reg & dimming_reg)))
        else $error("dim request does not match release mask");

    a_accept_fills: assert property (@(posedge clk) disable iff (!rst_n)
        in_accept |=> s1_valid_reg)
        else $error("accepted scan lost from lane stage");

endmodule

[sim/button_press_duration_classifier_test.sv]
`timescale 1ns / 100ps
// Self-checking test of button_press_duration_classifier: random and directed scans,
// a press-timing scoreboard and handshake drivers. Depends on bpdc_pkg and the RTL top.
module button_press_duration_classifier_test;

    import bpdc_pkg::*;

    typedef struct {
        press_class_t          indicator;
        logic [MASK_WIDTH-1:0] released;
        logic [MASK_WIDTH-1:0] long_rel;
        logic                  dim;
    } scan_result_t;

    class press_scoreboard;
        logic [ELAPSED_W-1:0]  min_ms;
        logic [ELAPSED_W-1:0]  long_ms;
        logic [TICK_W-1:0]     tick;
        logic [MASK_WIDTH-1:0] dim_mask;
        bit                    started[MASK_WIDTH];
        logic [ELAPSED_W-1:0]  elapsed[MASK_WIDTH];
        scan_result_t          expected_q[$];
        int                    errors;
        int                    scans;
        int                    results;

        function new();
            min_ms   = 16'd100;
            long_ms  = '0;
            tick     = 10'd100;
            dim_mask = '0;
            foreach (started[b]) begin
                started[b] = 1'b0;
                elapsed[b] = '0;
            end
            errors  = 0;
            scans   = 0;
            results = 0;
        endfunction

        function void write_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                REG_MIN_PRESS:  min_ms   = data;
                REG_LONG_PRESS: long_ms  = data;
                REG_TICK:       tick     = data[TICK_W-1:0];
                REG_DIMMING:    dim_mask = data[MASK_WIDTH-1:0];
                default: ;
            endcase
        endfunction

        function press_class_t grade(logic [ELAPSED_W-1:0] t);
            if (t <= min_ms)
                return CLS_NONE;
            if (long_ms != '0 && t > long_ms)
                return CLS_LONG;
            return CLS_SHORT;
        endfunction

        // saturating add of one scan period
        function logic [ELAPSED_W-1:0] add_tick(logic [ELAPSED_W-1:0] t);
            logic [ELAPSED_W:0] s;
            s = {1'b0, t} + {{(ELAPSED_W + 1 - TICK_W){1'b0}}, tick};
            if (s > {1'b0, ELAPSED_MAX})
                return ELAPSED_MAX;
            return s[ELAPSED_W-1:0];
        endfunction

        function void note_scan(logic [MASK_WIDTH-1:0] m);
            scan_result_t r;
            press_class_t k;
            r.indicator = CLS_NONE;
            r.released  = '0;
            r.long_rel  = '0;
            for (int b = 0; b < MASK_WIDTH; b++) begin
                if (m[b]) begin
                    if (!started[b]) begin
                        started[b] = 1'b1;
                        elapsed[b] = '0;
                    end
                    else begin
                        elapsed[b] = add_tick(elapsed[b]);
                    end
                    k = grade(elapsed[b]);
                    if (k != CLS_NONE)
                        r.indicator = k;
                end
                else begin
                    if (started[b]) begin
                        k = grade(add_tick(elapsed[b]));
                        if (k != CLS_NONE) begin
                            r.released[b] = 1'b1;
                            if (k == CLS_LONG)
                                r.long_rel[b] = 1'b1;
                        end
                    end
                    started[b] = 1'b0;
                    elapsed[b] = '0;
                end
            end
            r.dim = |(r.released & dim_mask);
            expected_q.push_back(r);
            scans++;
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        task report_mismatch(string what, logic [15:0] got, logic [15:0] want);
            $display("MISMATCH word %0d %s: got %h want %h", results, what, got, want);
            errors++;
        endtask

        task check_result(logic [1:0] ind, logic [MASK_WIDTH-1:0] rel,
                          logic [MASK_WIDTH-1:0] lng, logic dim);
            scan_result_t want;
            results++;
            if (expected_q.size() == 0) begin
                report_mismatch("unexpected word, released_mask", 16'(rel), '0);
            end
            else begin
                want = expected_q.pop_front();
                if (ind !== want.indicator)
                    report_mismatch("indicator", 16'(ind), 16'(want.indicator));
                if (rel !== want.released)
                    report_mismatch("released_mask", 16'(rel), 16'(want.released));
                if (lng !== want.long_rel)
                    report_mismatch("long_mask", 16'(lng), 16'(want.long_rel));
                if (dim !== want.dim)
                    report_mismatch("dim_request", 16'(dim), 16'(want.dim));
            end
        endtask
    endclass

    localparam int CYCLE_LIMIT = 500000;
    localparam int MAX_WAIT    = 17;
    localparam logic [CFG_INDEX_W-1:0] REG_SPARE_LAST = '1;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   in_valid = 1'b0;
    logic                   in_stall;
    logic [MASK_WIDTH-1:0]  pressed_mask = '0;
    logic                   out_valid;
    logic                   out_stall = 1'b0;
    logic [1:0]             indicator;
    logic [MASK_WIDTH-1:0]  released_mask;
    logic [MASK_WIDTH-1:0]  long_mask;
    logic                   dim_request;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data = '0;

    press_scoreboard        sb = new();

    // idling switches for the two sides, redrawn in chunks by the stimulus
    bit                     tx_idle = 1'b0;
    bit                     rx_idle = 1'b0;
    // one-shot long receiver hold-off, picked up by the receiver process
    int                     hold_off_cycles = 0;
    logic [MASK_WIDTH-1:0]  held_buttons = '0;
    int                     settings = 0;
    int                     cycles = 0;

    button_press_duration_classifier uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .pressed_mask  (pressed_mask),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .indicator     (indicator),
        .released_mask (released_mask),
        .long_mask     (long_mask),
        .dim_request   (dim_request),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    initial
    begin
        forever #4 clk = ~clk;
    end

    // Abort a hung run; the limit sits far above the slowest legal run.
    initial
    begin
        while (cycles < CYCLE_LIMIT) begin
            @(posedge clk);
            cycles++;
        end
        $display("Timeout after %0d cycles, %0d words still expected", cycles, sb.pending());
        $display("DONE: errors detected");
        $finish;
    end

    // Check every result word taken at a rising edge.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            sb.check_result(indicator, released_mask, long_mask, dim_request);
    end

    function automatic int draw_wait(bit on);
        return on ? $urandom_range(0, MAX_WAIT) : 0;
    endfunction

    // Receiver: stall a drawn number of cycles, then take one word.
    initial
    begin
        int n;
        @(posedge rst_n);
        forever begin
            if (hold_off_cycles > 0) begin
                n = hold_off_cycles;
                hold_off_cycles = 0;
            end
            else begin
                n = draw_wait(rx_idle);
            end
            if (n > 0) begin
                @(negedge clk);
                out_stall = 1'b1;
                repeat (n - 1) @(negedge clk);
            end
            @(negedge clk);
            out_stall = 1'b0;
            do @(posedge clk); while (!out_valid);
        end
    end

    // Offer one scan word after a drawn gap; hold it until taken.
    task automatic send_scan(input logic [MASK_WIDTH-1:0] m);
        int gap;
        gap = draw_wait(tx_idle);
        repeat (gap) begin
            @(negedge clk);
            in_valid = 1'b0;
        end
        @(negedge clk);
        in_valid     = 1'b1;
        pressed_mask = m;
        do @(posedge clk); while (in_stall);
        sb.note_scan(m);
    endtask

    // Drop valid and wait until every expected word has come back.
    task automatic drain();
        @(negedge clk);
        in_valid = 1'b0;
        while (sb.pending() != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_cfg(input logic [CFG_INDEX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        @(negedge clk);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data  = data;
        do @(posedge clk); while (!cfg_ready);
        sb.write_reg(idx, data);
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    task automatic program_regs(input logic [ELAPSED_W-1:0] min_ms,
                                input logic [ELAPSED_W-1:0] long_ms,
                                input logic [TICK_W-1:0] tick,
                                input logic [MASK_WIDTH-1:0] dim);
        drain();
        write_cfg(REG_MIN_PRESS, min_ms);
        write_cfg(REG_LONG_PRESS, long_ms);
        // junk above the tick field must be dropped by the block
        write_cfg(REG_TICK, {6'($urandom), tick});
        write_cfg(REG_DIMMING, {8'($urandom), dim});
        // an index past the register list must change nothing
        write_cfg(CFG_INDEX_W'($urandom_range(REG_DIMMING + 1, REG_SPARE_LAST)),
                  CFG_DATA_W'($urandom));
        settings++;
    endtask

    // Random scans: mostly buttons held over runs of scans, some noise words.
    // flip_den sets how often a button changes state, so how long presses last.
    task automatic random_scans(input int n_items, input int flip_den);
        logic [MASK_WIDTH-1:0] m;
        for (int i = 0; i < n_items; i++) begin
            if (i % 40 == 0) begin
                tx_idle = ($urandom_range(0, 2) != 0);
                rx_idle = ($urandom_range(0, 2) != 0);
            end
            if ($urandom_range(0, 9) == 0) begin
                m = MASK_WIDTH'($urandom);
            end
            else begin
                for (int b = 0; b < MASK_WIDTH; b++)
                    if ($urandom_range(1, flip_den) == 1)
                        held_buttons[b] = ~held_buttons[b];
                m = held_buttons;
            end
            send_scan(m);
        end
    endtask

    initial
    begin
        logic [MASK_WIDTH-1:0] warmup[$];
        logic [MASK_WIDTH-1:0] long_run[$];

        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Reset thresholds (min 100, long off, tick 100): a fresh press is judged
        // at zero, a release needs its advanced time over min, a release of an
        // unstarted button gives nothing, a swap of short presses gives nothing.
        warmup = '{8'h00, 8'hFF, 8'hFF, 8'hFF, 8'h7F, 8'h00, 8'h00, 8'h01, 8'h00,
                   8'h80, 8'h80, 8'h80, 8'h81, 8'h01, 8'h55, 8'hAA, 8'hAA, 8'hAA,
                   8'h00};
        foreach (warmup[i])
            send_scan(warmup[i]);

        // Long presses and a dimming release.
        program_regs(16'd100, 16'd250, 10'd100, 8'h81);
        long_run = '{8'h81, 8'h81, 8'h81, 8'h81, 8'h80, 8'h00};
        foreach (long_run[i])
            send_scan(long_run[i]);

        // Lowest thresholds and tick: one tick makes a press valid.
        program_regs(16'd0, 16'd0, 10'd1, 8'hFF);
        random_scans(110, 4);

        // Mid thresholds; hold off the output while scans keep coming so the
        // block backs up and stalls its input, then pause until all words return.
        program_regs(16'd300, 16'd700, 10'd100, 8'h0F);
        random_scans(20, 8);
        tx_idle = 1'b0;
        hold_off_cycles = 90;
        for (int i = 0; i < 40; i++)
            send_scan(MASK_WIDTH'($urandom));
        drain();
        random_scans(60, 8);

        // Top thresholds: elapsed saturates but never exceeds them.
        program_regs(16'hFFFF, 16'hFFFF, 10'd1000, 8'h00);
        held_buttons = '1;
        random_scans(100, 80);

        // Long presses reaching saturation.
        program_regs(16'd2000, 16'd60000, 10'd1000, MASK_WIDTH'($urandom));
        held_buttons = '1;
        random_scans(140, 60);

        // Zero tick freezes elapsed, so nothing is ever valid.
        program_regs(16'd0, 16'd0, 10'd0, 8'hFF);
        random_scans(60, 5);

        // Largest tick the field holds.
        program_regs(16'd1500, 16'd4000, 10'h3FF, 8'hA5);
        random_scans(110, 6);

        // Random settings.
        repeat (3) begin
            program_regs(ELAPSED_W'($urandom_range(0, 3000)),
                         ($urandom_range(0, 3) == 0) ? '0 :
                             ELAPSED_W'($urandom_range(0, 8000)),
                         TICK_W'($urandom_range(1, 1000)),
                         MASK_WIDTH'($urandom));
            random_scans(100, $urandom_range(3, 20));
        end

        drain();
        repeat (10) @(posedge clk);

        $display("Ran %0d scans through %0d threshold settings, %0d result words checked,",
                 sb.scans, settings + 1, sb.results);
        $display("with random gaps and stalls, a long output hold-off and saturated timers.");
        if (sb.errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
